// ----- rtl/core/binomial_cdf_table_sampler_top_defines.svh -----
// Assertion macros used by the checker file of the binomial sampler.
// Depends on nothing; each use expects clk and rst_n in scope.
`ifndef BINOMIAL_CDF_TABLE_SAMPLER_TOP_DEFINES_SVH
`define BINOMIAL_CDF_TABLE_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BCTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bcts_pkg.sv -----
// Shared types and constants of the binomial CDF table sampler.
// No dependencies.
package bcts_pkg;

    // Default table depth
    localparam int DEF_TABLE_DEPTH = 4096;

    // Item kinds carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_TRIAL_COUNT = 2'd0;
    localparam logic [1:0] CFG_MIRROR      = 2'd1;
    localparam logic [1:0] CFG_WEIGHT      = 2'd2;
    localparam logic [1:0] CFG_SEED        = 2'd3;

    // Seed spreading and mixer constants
    localparam logic [63:0] SEED_MUL = 64'h8F3F73B5CF1C9E3B;
    localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SM_MIX1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SM_MIX2  = 64'h94D049BB133111EB;

    // Field widths
    localparam int CNT_W  = 12;
    localparam int TGT_W  = 117;

    // Item payload that travels down the hash pipeline
    typedef struct packed {
        logic              op;
        logic [CNT_W-1:0]  idx;
        logic [63:0]       val;
    } item_t;

endpackage

// ----- rtl/core/binomial_cdf_table_sampler_top.sv -----
// Binomial sampler by inversion of a stored CDF table: hash pipeline plus search unit.
// Depends on bcts_pkg.
//
// Usage:
//   s_* carries items: tuser[0] is the opcode (0 writes a table entry, 1 draws).
//   tdata: entry_index [11:0], entry_value [75:12], sample_index [107:76].
//   m_* returns one draw_count per draw item, in tdata[11:0]; writes return none.
//   cfg_we/cfg_index/cfg_wdata write trial_count, mirror_result, total_weight,
//   base_seed (indexes 0..3); write them only while the block is idle.
// Timing:
//   Items pass a nine-stage hash and scaling pipeline that holds while its
//   last stage waits for the search unit, which then runs one table read a
//   cycle: up to ceil(log2(n+2)) reads, plus a start step and a hand-off
//   step; a write is taken without leaving idle. That single table
//   read port sets the sustained rate.
// Reset clears configuration, valids and the search state; the table itself
// holds whatever was written. A stalled receiver holds the result register;
// the search unit then waits and the pipeline stops, losing nothing.
module binomial_cdf_table_sampler_top #(
    parameter int TABLE_DEPTH = bcts_pkg::DEF_TABLE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,   // entry_index, entry_value, sample_index, zero pad
    input  logic [0:0]    s_tuser,   // opcode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,   // draw_count, zero pad
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_wdata
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NST    = 9;
    localparam int NMAX_I = (TABLE_DEPTH - 1 > 4095) ? 4095 : TABLE_DEPTH - 1;
    localparam logic [11:0] NMAX = 12'(NMAX_I);
    localparam int TW = bcts_pkg::TGT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Configuration registers
    logic [11:0] n_reg;
    logic        mir_reg;
    logic [63:0] weight_reg;
    logic [63:0] seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= '0;
            mir_reg    <= 1'b0;
            weight_reg <= '0;
            seed_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bcts_pkg::CFG_TRIAL_COUNT: n_reg      <= cfg_wdata[11:0];
                bcts_pkg::CFG_MIRROR:      mir_reg    <= cfg_wdata[0];
                bcts_pkg::CFG_WEIGHT:      weight_reg <= cfg_wdata;
                bcts_pkg::CFG_SEED:        seed_reg   <= cfg_wdata;
                default:                   n_reg      <= n_reg;
            endcase
        end
    end

    logic [11:0] nsat;
    assign nsat = (n_reg > NMAX) ? NMAX : n_reg;

    // Pipeline control
    logic                  vld_reg [NST];
    bcts_pkg::item_t       itm_reg [NST];
    logic                  adv;
    logic                  take;
    logic [1:0]            state_reg;

    assign take     = vld_reg[NST-1] && (state_reg == ST_IDLE);
    assign adv      = !vld_reg[NST-1] || take;
    assign s_tready = adv;

    // Advance valids and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            itm_reg[0] <= '{op: s_tuser[0], idx: s_tdata[11:0], val: s_tdata[75:12]};
            for (int i = 1; i < NST; i++)
            begin
                itm_reg[i] <= itm_reg[i-1];
            end
        end
    end

    // Hash and scaling datapath
    logic [32:0]     x0_reg;
    logic [63:0]     pa1_reg;
    logic [31:0]     pb1_reg;
    logic [63:0]     z2_reg;
    logic [63:0]     pa3_reg;
    logic [31:0]     pb3_reg;
    logic [63:0]     z4_reg;
    logic [63:0]     pa5_reg;
    logic [31:0]     pb5_reg;
    logic [52:0]     m6_reg;
    logic [63:0]     q00_reg;
    logic [63:0]     q01_reg;
    logic [52:0]     q10_reg;
    logic [52:0]     q11_reg;
    logic [TW-1:0]   tgt8_reg;

    logic [63:0]     s_next;
    logic [63:0]     z2_next;
    logic [63:0]     z4_sum;
    logic [63:0]     z6_sum;
    logic [63:0]     z6_mix;

    always_comb
    begin
        s_next  = seed_reg ^ (pa1_reg + {pb1_reg, 32'b0});
        z2_next = s_next + bcts_pkg::SM_GAMMA;
        z2_next = z2_next ^ (z2_next >> 30);
        z4_sum  = pa3_reg + {pb3_reg, 32'b0};
        z6_sum  = pa5_reg + {pb5_reg, 32'b0};
        z6_mix  = z6_sum ^ (z6_sum >> 31);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // index + 1
            x0_reg  <= {1'b0, s_tdata[107:76]} + 33'd1;
            // spread the index over 64 bits
            pa1_reg <= x0_reg[31:0] * bcts_pkg::SEED_MUL[31:0];
            pb1_reg <= 32'(x0_reg[31:0] * bcts_pkg::SEED_MUL[63:32])
                     + (x0_reg[32] ? bcts_pkg::SEED_MUL[31:0] : 32'd0);
            // seed, gamma, first xor-shift
            z2_reg  <= z2_next;
            // first mix multiply
            pa3_reg <= z2_reg[31:0] * bcts_pkg::SM_MIX1[31:0];
            pb3_reg <= 32'(z2_reg[31:0] * bcts_pkg::SM_MIX1[63:32])
                     + 32'(z2_reg[63:32] * bcts_pkg::SM_MIX1[31:0]);
            z4_reg  <= z4_sum ^ (z4_sum >> 27);
            // second mix multiply
            pa5_reg <= z4_reg[31:0] * bcts_pkg::SM_MIX2[31:0];
            pb5_reg <= 32'(z4_reg[31:0] * bcts_pkg::SM_MIX2[63:32])
                     + 32'(z4_reg[63:32] * bcts_pkg::SM_MIX2[31:0]);
            // top 53 bits, forced odd
            m6_reg  <= z6_mix[63:11] | 53'd1;
            // scale by the total weight in partial products
            q00_reg <= m6_reg[31:0] * weight_reg[31:0];
            q01_reg <= m6_reg[31:0] * weight_reg[63:32];
            q10_reg <= m6_reg[52:32] * weight_reg[31:0];
            q11_reg <= m6_reg[52:32] * weight_reg[63:32];
            tgt8_reg <= TW'(q00_reg) + (TW'(q01_reg) << 32) + (TW'(q10_reg) << 32)
                      + (TW'(q11_reg) << 64);
        end
    end

    // Table memory
    logic [63:0]    mem [TABLE_DEPTH];
    logic [63:0]    rd_data_reg;
    logic           mem_we;
    logic           mem_re;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= itm_reg[NST-1].val;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Search unit
    logic [12:0]    lo_reg;
    logic [12:0]    hi_reg;
    logic [12:0]    mid_reg;
    logic [TW-1:0]  tgt_reg;
    logic [11:0]    k_reg;
    logic           out_valid_reg;
    logic [11:0]    out_data_reg;
    logic           out_free;

    logic           ge;
    logic [12:0]    lo_n;
    logic [12:0]    hi_n;
    logic [12:0]    mid_n;
    logic [12:0]    hi_start;
    logic [12:0]    mid_start;
    logic [11:0]    k_n;
    logic           in_range;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        ge        = {rd_data_reg, 53'b0} >= tgt_reg;
        lo_n      = ge ? lo_reg : mid_reg + 13'd1;
        hi_n      = ge ? mid_reg : hi_reg;
        mid_n     = lo_n + ((hi_n - lo_n) >> 1);
        hi_start  = {1'b0, nsat} + 13'd1;
        mid_start = hi_start >> 1;
        k_n       = (lo_n > {1'b0, nsat}) ? nsat : lo_n[11:0];
        in_range  = {20'b0, itm_reg[NST-1].idx} < 32'(TABLE_DEPTH);
        waddr     = AW'(itm_reg[NST-1].idx);
        mem_we    = take && (itm_reg[NST-1].op == bcts_pkg::OP_WRITE) && in_range;
        mem_re    = 1'b0;
        raddr     = AW'(mid_start);
        case (state_reg)
            ST_IDLE:
            begin
                mem_re = take && (itm_reg[NST-1].op == bcts_pkg::OP_DRAW);
            end
            ST_BUSY:
            begin
                mem_re = lo_n < hi_n;
                raddr  = AW'(mid_n);
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise the result on hand-off, drop it once taken
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take && (itm_reg[NST-1].op == bcts_pkg::OP_DRAW))
                    begin
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY:
                begin
                    if (!(lo_n < hi_n))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Search payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                lo_reg  <= '0;
                hi_reg  <= hi_start;
                mid_reg <= mid_start;
                tgt_reg <= tgt8_reg;
            end
            ST_BUSY:
            begin
                lo_reg  <= lo_n;
                hi_reg  <= hi_n;
                mid_reg <= mid_n;
                k_reg   <= k_n;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= mir_reg ? (nsat - k_reg) : k_reg;
                end
            end
            default:
            begin
                lo_reg <= lo_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_data_reg};

endmodule

// ----- rtl/core/bcts_checker.sv -----
// Port-level checks of the binomial sampler, bound to the top level.
// Depends on bcts_pkg and binomial_cdf_table_sampler_top_defines.svh.
`include "binomial_cdf_table_sampler_top_defines.svh"

module bcts_checker #(
    parameter int TABLE_DEPTH = bcts_pkg::DEF_TABLE_DEPTH
) (
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [111:0]  s_tdata,
    input logic [0:0]    s_tuser,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [15:0]   m_tdata,
    input logic          cfg_we,
    input logic [1:0]    cfg_index,
    input logic [63:0]   cfg_wdata
);

    localparam int NMAX_I = (TABLE_DEPTH - 1 > 4095) ? 4095 : TABLE_DEPTH - 1;
    localparam logic [11:0] NMAX = 12'(NMAX_I);

    logic [11:0] n_reg;
    logic [4:0]  pend_reg;
    logic [4:0]  pend_next;
    logic        draw_in;
    logic        res_out;
    logic [11:0] nsat;

    assign draw_in = s_tvalid && s_tready && (s_tuser[0] == bcts_pkg::OP_DRAW)
                   && (s_tdata[111:108] == 4'b0 || s_tdata[111:108] != 4'b0);
    assign res_out = m_tvalid && m_tready;
    assign nsat    = (n_reg > NMAX) ? NMAX : n_reg;

    always_comb
    begin
        pend_next = pend_reg + {4'b0, draw_in} - {4'b0, res_out};
    end

    // Track trial count and draws awaiting a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg_we && cfg_index == bcts_pkg::CFG_TRIAL_COUNT)
            begin
                n_reg <= cfg_wdata[11:0];
            end
        end
    end

    `BCTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `BCTS_ASSERT_NOW(a_out_range, m_tvalid, m_tdata[11:0] <= nsat && m_tdata[15:12] == 4'b0, "draw beyond trial count")
    `BCTS_ASSERT_NOW(a_no_invent, m_tvalid, pend_reg != 5'd0, "result without a pending draw")

endmodule

bind binomial_cdf_table_sampler_top bcts_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_bcts_checker (.*);

// ----- bench/tb.sv -----
// Testbench for binomial_cdf_table_sampler_top: table writes and draws checked
// against an in-bench binomial inversion predictor. Depends on bcts_pkg and the RTL.
module tb;

    localparam int DEPTH = bcts_pkg::DEF_TABLE_DEPTH;
    localparam int LIMIT_CYCLES = 900000;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [111:0]  s_tdata;   // entry_index, entry_value, sample_index, zero pad
    logic [0:0]    s_tuser;   // opcode
    logic          m_tvalid;
    logic          m_tready;
    logic [15:0]   m_tdata;   // draw_count, zero pad
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [63:0]   cfg_wdata;

    binomial_cdf_table_sampler_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Predictor state
    logic [63:0] cdf_copy [DEPTH];
    logic [11:0] n_trials;
    logic        mirror_on;
    logic [63:0] weight;
    logic [63:0] seed;

    logic [11:0] draw_queue [$];
    int          mismatches;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          timed_out;

    // Directed table rows
    typedef struct {
        logic        op;
        logic [11:0] idx;
        logic [63:0] val;
        logic [31:0] sidx;
        bit          has_fixed;
        logic [11:0] fixed_count;
    } row_t;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] splitmix(input logic [63:0] s);
        logic [63:0] z;
        z = s + bcts_pkg::SM_GAMMA;
        z = (z ^ (z >> 30)) * bcts_pkg::SM_MIX1;
        z = (z ^ (z >> 27)) * bcts_pkg::SM_MIX2;
        return z ^ (z >> 31);
    endfunction

    // Lower-bound search over the table copy
    function automatic logic [11:0] predict_draw(input logic [31:0] sidx);
        logic [63:0]  m;
        logic [127:0] target;
        logic [127:0] scaled;
        int lo;
        int hi;
        int mid;
        int k;
        m = (splitmix(seed ^ (bcts_pkg::SEED_MUL * ({32'd0, sidx} + 64'd1))) >> 11) | 64'd1;
        target = {64'd0, m} * {64'd0, weight};
        lo = 0;
        hi = n_trials + 1;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            scaled = {64'd0, cdf_copy[mid]} << 53;
            if (scaled >= target)
                hi = mid;
            else
                lo = mid + 1;
        end
        k = (lo > n_trials) ? n_trials : lo;
        return mirror_on ? 12'(n_trials - k) : 12'(k);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bcts_pkg::CFG_TRIAL_COUNT: n_trials = v[11:0];
            bcts_pkg::CFG_MIRROR:      mirror_on = v[0];
            bcts_pkg::CFG_WEIGHT:      weight = v;
            bcts_pkg::CFG_SEED:        seed = v;
            default:                   seed = seed;
        endcase
    endtask

    // Drive one item and wait for acceptance; record its expectation
    task automatic send_item(input logic op, input logic [11:0] idx, input logic [63:0] val,
                             input logic [31:0] sidx, input bit has_fixed,
                             input logic [11:0] fixed_count);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'd0, sidx, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (op == bcts_pkg::OP_WRITE)
            cdf_copy[idx] = val;
        else
            draw_queue.push_back(has_fixed ? fixed_count : predict_draw(sidx));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (draw_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Fill entries 0..n with random running sums, the last entry set to the total weight
    task automatic build_table(input int n, input logic [63:0] tot);
        logic [63:0] acc;
        logic [63:0] stepv;
        acc = 64'd0;
        stepv = (tot / (n + 1)) + 64'd1;
        for (int i = 0; i <= n; i++)
        begin
            acc = acc + (stepv == 0 ? 64'd0 : ({$urandom, $urandom} % (2 * stepv)));
            if (i == n || acc > tot)
                acc = (i == n) ? tot : acc;
            send_item(bcts_pkg::OP_WRITE, 12'(i), acc, 32'd0, 1'b0, 12'd0);
        end
    endtask

    task automatic draw_burst(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(bcts_pkg::OP_WRITE, 12'($urandom_range(n_trials)),
                          cdf_copy[$urandom_range(n_trials)], $urandom, 1'b0, 12'd0);
            else
                send_item(bcts_pkg::OP_DRAW, 12'($urandom), {$urandom, $urandom},
                          $urandom, 1'b0, 12'd0);
        end
    endtask

    // Compare returned draws with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (draw_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected draw_count %0d", m_tdata[11:0]);
            end
            else
            begin
                if (m_tdata[11:0] !== draw_queue[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("draw_count expected %0d got %0d",
                                 draw_queue[0], m_tdata[11:0]);
                end
                void'(draw_queue.pop_front());
            end
        end
    end

    // Receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        row_t rows [$];
        int ns [4];
        int phase;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        mismatches = 0;
        cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_trials = '0;
        mirror_on = 1'b0;
        weight = '0;
        seed = '0;
        foreach (cdf_copy[i])
            cdf_copy[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset n is zero: only entry 0 is searched, so the draw gives 0
        rows.push_back('{bcts_pkg::OP_WRITE, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0,
                         1'b0, 12'd0});
        rows.push_back('{bcts_pkg::OP_DRAW, 12'd0, 64'd0, 32'd0, 1'b1, 12'd0});
        rows.push_back('{bcts_pkg::OP_DRAW, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                         1'b1, 12'd0});
        foreach (rows[i])
            send_item(rows[i].op, rows[i].idx, rows[i].val, rows[i].sidx,
                      rows[i].has_fixed, rows[i].fixed_count);
        wait_idle();

        // Small table, zero weight lands on index 0; then max weight, none reaches
        rows.delete();
        write_reg(bcts_pkg::CFG_TRIAL_COUNT, 64'd3);
        write_reg(bcts_pkg::CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 4; i++)
            rows.push_back('{bcts_pkg::OP_WRITE, 12'(i), 64'(i) << 40, 32'd0, 1'b0, 12'd0});
        rows.push_back('{bcts_pkg::OP_DRAW, 12'd0, 64'd0, 32'd7, 1'b1, 12'd0});
        rows.push_back('{bcts_pkg::OP_DRAW, 12'd0, 64'd0, 32'hFFFF_FFFF, 1'b1, 12'd0});
        foreach (rows[i])
            send_item(rows[i].op, rows[i].idx, rows[i].val, rows[i].sidx,
                      rows[i].has_fixed, rows[i].fixed_count);
        wait_idle();
        write_reg(bcts_pkg::CFG_WEIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(bcts_pkg::OP_DRAW, 12'd0, 64'd0, 32'd1, 1'b1, 12'd3);
        send_item(bcts_pkg::OP_DRAW, 12'd0, 64'd0, 32'd2, 1'b0, 12'd0);
        wait_idle();
        write_reg(bcts_pkg::CFG_MIRROR, 64'd1);
        send_item(bcts_pkg::OP_DRAW, 12'd0, 64'd0, 32'd3, 1'b1, 12'd0);
        wait_idle();
        write_reg(bcts_pkg::CFG_WEIGHT, 64'd4 << 40);
        send_item(bcts_pkg::OP_DRAW, 12'd0, 64'd0, 32'h8000_0000, 1'b0, 12'd0);
        wait_idle();

        // Random phases over several table sizes
        ns = '{400, 1, 20, 200};
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            write_reg(bcts_pkg::CFG_TRIAL_COUNT, 64'(ns[phase]));
            write_reg(bcts_pkg::CFG_MIRROR, 64'($urandom_range(1)));
            write_reg(bcts_pkg::CFG_WEIGHT, (phase == 0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                           : {$urandom, $urandom} >> $urandom_range(40));
            write_reg(bcts_pkg::CFG_SEED, {$urandom, $urandom});
            if (phase != 0)
                build_table(ns[phase], weight);
            else
            begin
                // Ramp the low entries, then park the top eight just under full weight
                for (int i = 0; i < ns[0] - 7; i++)
                    send_item(bcts_pkg::OP_WRITE, 12'(i), 64'(i) << 52,
                              32'd0, 1'b0, 12'd0);
                for (int i = 0; i < 8; i++)
                    send_item(bcts_pkg::OP_WRITE, 12'(ns[0] - 7 + i),
                              64'hFFFF_FFFF_FFFF_FFF0 + 64'(i), 32'd0, 1'b0, 12'd0);
            end
            draw_burst(phase == 0 ? 100 : 300);
            wait_idle();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
